[hw/rtl/ptt_pkg.sv]
// Package for the periodic task timer table: field widths, codes, command and
// table entry types, and the back-end state type. No dependencies.
`timescale 1ns / 1ps

package ptt_pkg;

	localparam int SLOTS_DEF = 16;

	localparam int MODE_W   = 2;
	localparam int PERIOD_W = 24;
	localparam int SLOT_W   = 4;
	localparam int KIND_W   = 3;
	localparam int TICK_W   = 16;
	localparam int ACCUM_W  = 25;

	localparam logic [TICK_W-1:0] MIN_TICK = 16'd50;

	localparam logic [MODE_W-1:0] MODE_ADD    = 2'd0;
	localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;
	localparam logic [MODE_W-1:0] MODE_TICK   = 2'd2;

	localparam logic [KIND_W-1:0] KIND_ADDED     = 3'd0;
	localparam logic [KIND_W-1:0] KIND_REMOVED   = 3'd1;
	localparam logic [KIND_W-1:0] KIND_FIRED     = 3'd2;
	localparam logic [KIND_W-1:0] KIND_DONE      = 3'd3;
	localparam logic [KIND_W-1:0] KIND_FULL      = 3'd4;
	localparam logic [KIND_W-1:0] KIND_NOT_FOUND = 3'd5;

	// The command queue depth must be a power of two so the pointers wrap.
	localparam int Q_DEPTH = 2;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);
	localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

	typedef enum logic [1:0] {
		OP_ADD,
		OP_REMOVE,
		OP_TICK
	} op_t;

	typedef struct packed {
		op_t                 op;
		logic [PERIOD_W-1:0] period;
		logic [SLOT_W-1:0]   slot;
		logic                slot_ok;
	} cmd_t;

	typedef struct packed {
		logic [PERIOD_W-1:0] period;
		logic [ACCUM_W-1:0]  accum;
	} entry_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_DONE
	} back_state_t;

endpackage

[hw/rtl/ptt_if.sv]
// Valid/ready channel interfaces for the timer table input and result items.
// Depends on ptt_pkg for the field widths.
`timescale 1ns / 1ps

interface ptt_in_if;
	logic                         valid;
	logic                         ready;
	logic [ptt_pkg::MODE_W-1:0]   mode;
	logic [ptt_pkg::PERIOD_W-1:0] period;
	logic [ptt_pkg::SLOT_W-1:0]   slot;

	modport source (output valid, mode, period, slot, input ready);
	modport sink (input valid, mode, period, slot, output ready);
endinterface

interface ptt_out_if;
	logic                       valid;
	logic                       ready;
	logic [ptt_pkg::KIND_W-1:0] kind;
	logic [ptt_pkg::SLOT_W-1:0] slot_out;
	logic                       last;

	modport source (output valid, kind, slot_out, last, input ready);
	modport sink (input valid, kind, slot_out, last, output ready);
endinterface

[hw/rtl/ptt_front.sv]
// Front end: accepts input items, drops unused modes, clamps the add period
// to the base tick and range-checks the remove slot. Uses ptt_pkg and ptt_in_if.
`timescale 1ns / 1ps

module ptt_front #(
	parameter int SLOTS = ptt_pkg::SLOTS_DEF
) (
	ptt_in_if.sink                     in_ch,
	input  logic [ptt_pkg::TICK_W-1:0] base_tick,
	output ptt_pkg::cmd_t              push_cmd,
	output logic                       push_valid,
	input  logic                       push_ready
);
	import ptt_pkg::*;

	logic [PERIOD_W-1:0] tick_ext;
	logic                known_mode;

	assign in_ch.ready = push_ready;
	assign tick_ext    = PERIOD_W'(base_tick);

	always_comb begin
		known_mode = (in_ch.mode == MODE_ADD) || (in_ch.mode == MODE_REMOVE)
			|| (in_ch.mode == MODE_TICK);
		push_valid = in_ch.valid && known_mode;
		case (in_ch.mode)
			MODE_ADD:    push_cmd.op = OP_ADD;
			MODE_REMOVE: push_cmd.op = OP_REMOVE;
			default:     push_cmd.op = OP_TICK;
		endcase
		push_cmd.period  = (in_ch.period > tick_ext) ? in_ch.period : tick_ext;
		push_cmd.slot    = in_ch.slot;
		push_cmd.slot_ok = int'(in_ch.slot) < SLOTS;
	end

endmodule

[hw/rtl/ptt_cmd_queue.sv]
// Short command queue between the front end and the back end.
// Depends on ptt_pkg for the command type and depth.
`timescale 1ns / 1ps

module ptt_cmd_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  ptt_pkg::cmd_t push_cmd,
	input  logic          push_valid,
	output logic          push_ready,
	output ptt_pkg::cmd_t head,
	output logic          head_valid,
	input  logic          head_pop
);
	import ptt_pkg::*;

	cmd_t               q_mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q;
	logic [Q_PTR_W-1:0] rd_ptr_q;
	logic [Q_CNT_W-1:0] cnt_q;
	logic               do_push;
	logic               do_pop;

	assign push_ready = cnt_q != Q_CNT_W'(Q_DEPTH);
	assign head_valid = cnt_q != '0;
	assign head       = q_mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = head_pop && head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_push && !do_pop) cnt_q <= cnt_q + 1'b1;
			else if (!do_push && do_pop) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) q_mem_q[wr_ptr_q] <= push_cmd;
	end

endmodule

[hw/rtl/ptt_back.sv]
// Back end: executes add, remove and tick commands against the slot table
// and drives the registered result channel. Uses ptt_pkg and ptt_out_if.
`timescale 1ns / 1ps

module ptt_back #(
	parameter int SLOTS = ptt_pkg::SLOTS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [ptt_pkg::TICK_W-1:0] base_tick,
	input  ptt_pkg::cmd_t              head,
	input  logic                       head_valid,
	output logic                       head_pop,
	ptt_out_if.source                  out_ch
);
	import ptt_pkg::*;

	localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	back_state_t        state_q;
	back_state_t        state_d;
	logic [IDX_W-1:0]   idx_q;
	logic [IDX_W-1:0]   idx_d;
	logic [SLOTS-1:0]   valid_q;
	entry_t             mem [SLOTS];
	entry_t             rd_q;

	logic               mem_we;
	logic [IDX_W-1:0]   mem_wa;
	entry_t             mem_wd;
	logic               set_en;
	logic               clr_en;
	logic [IDX_W-1:0]   vidx;

	logic               free_found;
	logic [IDX_W-1:0]   free_idx;
	logic [IDX_W-1:0]   rm_idx;
	logic               rm_hit;
	logic [IDX_W+SLOT_W-1:0] free_ext;
	logic [IDX_W+SLOT_W-1:0] walk_ext;
	logic [ACCUM_W-1:0] sum;
	logic               step;

	logic               emit_ok;
	logic               emit;
	logic [KIND_W-1:0]  e_kind;
	logic [SLOT_W-1:0]  e_slot;
	logic               e_last;

	logic               ovalid_q;
	logic [KIND_W-1:0]  okind_q;
	logic [SLOT_W-1:0]  oslot_q;
	logic               olast_q;

	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_found = 1'b1;
				free_idx   = IDX_W'(i);
			end
		end
	end

	assign rm_idx   = IDX_W'(head.slot);
	assign rm_hit   = head.slot_ok && valid_q[rm_idx];
	assign free_ext = {{SLOT_W{1'b0}}, free_idx};
	assign walk_ext = {{SLOT_W{1'b0}}, idx_q};
	assign sum      = rd_q.accum + ACCUM_W'(base_tick);
	assign emit_ok  = !ovalid_q || out_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		idx_d    = idx_q;
		head_pop = 1'b0;
		emit     = 1'b0;
		e_kind   = KIND_DONE;
		e_slot   = '0;
		e_last   = 1'b1;
		mem_we   = 1'b0;
		mem_wa   = idx_q;
		mem_wd   = rd_q;
		set_en   = 1'b0;
		clr_en   = 1'b0;
		vidx     = idx_q;
		step     = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (head_valid && emit_ok) begin
					head_pop = 1'b1;
					case (head.op)
						OP_ADD: begin
							emit = 1'b1;
							if (free_found) begin
								e_kind       = KIND_ADDED;
								e_slot       = free_ext[SLOT_W-1:0];
								set_en       = 1'b1;
								vidx         = free_idx;
								mem_we       = 1'b1;
								mem_wa       = free_idx;
								mem_wd.period = head.period;
								mem_wd.accum  = '0;
							end else begin
								e_kind = KIND_FULL;
							end
						end
						OP_REMOVE: begin
							emit = 1'b1;
							if (rm_hit) begin
								e_kind = KIND_REMOVED;
								e_slot = head.slot;
								clr_en = 1'b1;
								vidx   = rm_idx;
							end else begin
								e_kind = KIND_NOT_FOUND;
							end
						end
						default: begin
							state_d = ST_WALK;
							idx_d   = '0;
						end
					endcase
				end
			end
			ST_WALK: begin
				if (!valid_q[idx_q]) begin
					step = 1'b1;
				end else if (sum >= {1'b0, rd_q.period}) begin
					if (emit_ok) begin
						emit         = 1'b1;
						e_kind       = KIND_FIRED;
						e_slot       = walk_ext[SLOT_W-1:0];
						e_last       = 1'b0;
						mem_we       = 1'b1;
						mem_wd.accum = '0;
						step         = 1'b1;
					end
				end else begin
					mem_we       = 1'b1;
					mem_wd.accum = sum;
					step         = 1'b1;
				end
				if (step) begin
					if (idx_q == IDX_W'(SLOTS - 1)) state_d = ST_DONE;
					else idx_d = idx_q + 1'b1;
				end
			end
			ST_DONE: begin
				if (emit_ok) begin
					emit    = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (set_en) valid_q[vidx] <= 1'b1;
			if (clr_en) valid_q[vidx] <= 1'b0;
		end
	end

	// The read address follows the next walk index, so the entry of the
	// current index is already registered while the walk is on it.
	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_wa] <= mem_wd;
		rd_q <= mem[idx_d];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else begin
			if (emit) ovalid_q <= 1'b1;
			else if (out_ch.ready) ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			okind_q <= e_kind;
			oslot_q <= e_slot;
			olast_q <= e_last;
		end
	end

	assign out_ch.valid    = ovalid_q;
	assign out_ch.kind     = okind_q;
	assign out_ch.slot_out = oslot_q;
	assign out_ch.last     = olast_q;

endmodule

[hw/rtl/periodic_task_timer_table.sv]
// Top level of the periodic task timer table: base tick register, front end,
// command queue and back end. Uses ptt_pkg, ptt_if and the ptt_* modules.
//
// Usage: input items arrive on in_ch (mode, period, slot) and result items
// leave on out_ch (kind, slot_out, last); both are valid/ready channels.
// base_tick is written through cfg_we/cfg_wdata; the user must do so only
// while the block is idle, which the block does not enforce; values below
// 50 are stored as 50. An add or remove gives one result: the item passes
// the command queue, the back end handles it in its idle state, and the
// result goes to the output register. A tick runs in steps in the back end:
// a start in the idle state, a walk over every slot of the period/accumulator
// memory, then the tick_done result. A fire stalls only if out_ch stalls.
// Unused mode 3 is accepted and dropped without a result.
// A two-entry command queue lets in_ch keep accepting items while the back
// end works or out_ch stalls; in_ch.ready falls only when the queue is full.
// Results sit in an output register until out_ch.ready takes them.
// Reset clears all slots to free and base_tick to 50; no clearing pass.
`timescale 1ns / 1ps

module periodic_task_timer_table #(
	parameter int SLOTS = ptt_pkg::SLOTS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [ptt_pkg::TICK_W-1:0] cfg_wdata,
	ptt_in_if.sink                     in_ch,
	ptt_out_if.source                  out_ch
);
	import ptt_pkg::*;

	logic [TICK_W-1:0] base_tick_q;
	cmd_t              push_cmd;
	logic              push_valid;
	logic              push_ready;
	cmd_t              head;
	logic              head_valid;
	logic              head_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_tick_q <= MIN_TICK;
		end else if (cfg_we) begin
			base_tick_q <= (cfg_wdata < MIN_TICK) ? MIN_TICK : cfg_wdata;
		end
	end

	ptt_front #(
		.SLOTS(SLOTS)
	) u_front (
		.in_ch     (in_ch),
		.base_tick (base_tick_q),
		.push_cmd  (push_cmd),
		.push_valid(push_valid),
		.push_ready(push_ready)
	);

	ptt_cmd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_cmd  (push_cmd),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.head      (head),
		.head_valid(head_valid),
		.head_pop  (head_pop)
	);

	ptt_back #(
		.SLOTS(SLOTS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.base_tick (base_tick_q),
		.head      (head),
		.head_valid(head_valid),
		.head_pop  (head_pop),
		.out_ch    (out_ch)
	);

endmodule

[hw/rtl/ptt_checker.sv]
// Port-level checks on the result channel of the timer table, bound to the
// top level. Depends on ptt_pkg for the result codes.
`timescale 1ns / 1ps

module ptt_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic [ptt_pkg::KIND_W-1:0] out_kind,
	input logic [ptt_pkg::SLOT_W-1:0] out_slot,
	input logic                       out_last
);
	import ptt_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable({out_kind, out_slot, out_last}))
		else $error("result item changed while stalled");

	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_kind == KIND_ADDED) || (out_kind == KIND_REMOVED)
			|| (out_kind == KIND_FIRED) || (out_kind == KIND_DONE)
			|| (out_kind == KIND_FULL) || (out_kind == KIND_NOT_FOUND))
		else $error("illegal result kind");

	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_last == (out_kind != KIND_FIRED)))
		else $error("last flag does not match result kind");

	a_slot: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && ((out_kind == KIND_DONE) || (out_kind == KIND_FULL)
			|| (out_kind == KIND_NOT_FOUND)) |-> out_slot == '0)
		else $error("nonzero slot on a result without a slot");

endmodule

bind periodic_task_timer_table ptt_checker u_ptt_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.out_valid(out_ch.valid),
	.out_ready(out_ch.ready),
	.out_kind (out_ch.kind),
	.out_slot (out_ch.slot_out),
	.out_last (out_ch.last)
);

[dv/tb_periodic_task_timer_table.sv]
// Testbench for the periodic task timer table: directed and random add, remove and tick
// items, checked against a scoreboard that keeps its own copy of the slot table.
// Depends on ptt_pkg, ptt_if and the periodic_task_timer_table RTL.
`timescale 1ns / 1ps

module tb;
	import ptt_pkg::*;

	localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
	localparam int SETTLE_CYCLES = 2 * (SLOTS_DEF + 2) + 4;
	localparam int QUIET_LIMIT = 2000;
	localparam int RANDOM_PER_SETTING = 42;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [SLOT_W-1:0] slot_out;
		logic              last;
	} timer_result_t;

	class timer_table_scoreboard;
		logic [TICK_W-1:0]   base_tick;
		logic [SLOTS_DEF-1:0] slot_busy;
		logic [PERIOD_W-1:0] slot_period [SLOTS_DEF];
		logic [ACCUM_W-1:0]  slot_accum [SLOTS_DEF];
		timer_result_t       expected_q [$];
		int                  errors;

		function new();
			base_tick = MIN_TICK;
			slot_busy = '0;
			errors = 0;
		endfunction

		function void write_base_tick(logic [TICK_W-1:0] value);
			base_tick = (value < MIN_TICK) ? MIN_TICK : value;
		endfunction

		function void push_result(logic [KIND_W-1:0] kind, int slot, logic last);
			timer_result_t r;
			r.kind = kind;
			r.slot_out = slot[SLOT_W-1:0];
			r.last = last;
			expected_q.push_back(r);
		endfunction

		function void note_item(logic [MODE_W-1:0] mode, logic [PERIOD_W-1:0] period,
				logic [SLOT_W-1:0] slot);
			int free_slot;
			free_slot = -1;
			case (mode)
				MODE_ADD: begin
					for (int i = SLOTS_DEF - 1; i >= 0; i--)
						if (!slot_busy[i])
							free_slot = i;
					if (free_slot < 0) begin
						push_result(KIND_FULL, 0, 1'b1);
					end else begin
						slot_busy[free_slot] = 1'b1;
						slot_period[free_slot] = (period > base_tick) ? period :
							PERIOD_W'(base_tick);
						slot_accum[free_slot] = '0;
						push_result(KIND_ADDED, free_slot, 1'b1);
					end
				end
				MODE_REMOVE: begin
					if (slot_busy[slot]) begin
						slot_busy[slot] = 1'b0;
						push_result(KIND_REMOVED, slot, 1'b1);
					end else begin
						push_result(KIND_NOT_FOUND, 0, 1'b1);
					end
				end
				MODE_TICK: begin
					for (int i = 0; i < SLOTS_DEF; i++) begin
						if (slot_busy[i]) begin
							slot_accum[i] = slot_accum[i] + base_tick;
							if (slot_accum[i] >= slot_period[i]) begin
								slot_accum[i] = '0;
								push_result(KIND_FIRED, i, 1'b0);
							end
						end
					end
					push_result(KIND_DONE, 0, 1'b1);
				end
				default: begin
				end
			endcase
		endfunction

		task report(string msg);
			$display("[%0t] mismatch: %s", $realtime, msg);
			errors++;
		endtask

		task check_result(logic [KIND_W-1:0] kind, logic [SLOT_W-1:0] slot_out, logic last);
			timer_result_t exp_r;
			if (expected_q.size() == 0) begin
				report($sformatf("unexpected item kind %0d slot %0d last %0d",
					kind, slot_out, last));
			end else begin
				exp_r = expected_q.pop_front();
				if (kind !== exp_r.kind)
					report($sformatf("kind %0d, expected %0d", kind, exp_r.kind));
				if (slot_out !== exp_r.slot_out)
					report($sformatf("slot_out %0d, expected %0d", slot_out, exp_r.slot_out));
				if (last !== exp_r.last)
					report($sformatf("last %0d, expected %0d", last, exp_r.last));
			end
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [TICK_W-1:0] cfg_wdata;
	int send_idle_pct;
	int recv_idle_pct;
	int quiet_cycles;

	ptt_in_if in_ch ();
	ptt_out_if out_ch ();

	timer_table_scoreboard sb = new();

	periodic_task_timer_table u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_ch     (in_ch),
		.out_ch    (out_ch)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		out_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_ch.valid && out_ch.ready)
				sb.check_result(out_ch.kind, out_ch.slot_out, out_ch.last);
			out_ch.ready <= arst_n && ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("periodic_task_timer_table verification failed");
				$finish;
			end
		end
	end

	task automatic send_item(input logic [MODE_W-1:0] mode, input logic [PERIOD_W-1:0] period,
			input logic [SLOT_W-1:0] slot);
		while ($urandom_range(99) < send_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.mode <= mode;
		in_ch.period <= period;
		in_ch.slot <= slot;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		sb.note_item(mode, period, slot);
	endtask

	task automatic write_base_tick(input logic [TICK_W-1:0] value);
		in_ch.valid <= 1'b0;
		while (sb.expected_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.write_base_tick(value);
	endtask

	function automatic logic [PERIOD_W-1:0] random_period();
		logic [31:0] p;
		case ($urandom_range(9))
			0: p = $urandom;
			1: p = $urandom_range(sb.base_tick);
			default: p = sb.base_tick * $urandom_range(1, 6) + $urandom_range(sb.base_tick)
				- sb.base_tick / 2;
		endcase
		return p[PERIOD_W-1:0];
	endfunction

	task automatic random_item();
		int pick;
		logic [PERIOD_W-1:0] period;
		logic [SLOT_W-1:0] slot;
		pick = $urandom_range(99);
		period = random_period();
		slot = SLOT_W'($urandom);
		if (pick < 30) begin
			send_item(MODE_ADD, period, slot);
		end else if (pick < 55) begin
			if ($urandom_range(3) != 0 && sb.slot_busy != '0) begin
				while (!sb.slot_busy[slot])
					slot = SLOT_W'($urandom);
			end
			send_item(MODE_REMOVE, period, slot);
		end else if (pick < 95) begin
			send_item(MODE_TICK, period, slot);
		end else begin
			send_item(MODE_UNUSED, period, slot);
		end
	endtask

	initial begin
		logic [TICK_W-1:0] tick_settings [6];
		tick_settings = '{16'd0, 16'hFFFF, 16'd49, 16'd100, 16'd51, 16'd50};
		tick_settings[3] = $urandom_range(52, 65534);
		arst_n = 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		in_ch.valid <= 1'b0;
		in_ch.mode <= MODE_ADD;
		in_ch.period <= '0;
		in_ch.slot <= '0;
		send_idle_pct = 10;
		recv_idle_pct = 82;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_item(MODE_ADD, 24'd0, 4'd0);
		send_item(MODE_ADD, 24'hFFFFFF, 4'hF);
		send_item(MODE_ADD, 24'd120, 4'd0);
		send_item(MODE_TICK, 24'hFFFFFF, 4'hF);
		send_item(MODE_TICK, 24'd0, 4'd0);
		send_item(MODE_REMOVE, 24'd0, 4'd1);
		send_item(MODE_REMOVE, 24'd0, 4'd1);
		send_item(MODE_REMOVE, 24'd0, 4'hF);
		send_item(MODE_UNUSED, 24'hFFFFFF, 4'hF);
		send_item(MODE_ADD, 24'd49, 4'd0);
		for (int i = 0; i < SLOTS_DEF - 3; i++)
			send_item(MODE_ADD, 24'd50, 4'd0);
		send_item(MODE_ADD, 24'd60, 4'd0);
		send_item(MODE_TICK, 24'd0, 4'd0);

		for (int ph = 0; ph < 3; ph++) begin
			send_idle_pct = (ph == 0) ? 10 : (ph == 1) ? 82 : 0;
			recv_idle_pct = (ph == 0) ? 82 : (ph == 1) ? 10 : 0;
			for (int seg = 0; seg < 2; seg++) begin
				write_base_tick(tick_settings[ph * 2 + seg]);
				for (int n = 0; n < RANDOM_PER_SETTING; n++)
					random_item();
			end
		end

		in_ch.valid <= 1'b0;
		while (sb.expected_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.errors == 0) begin
			$display("periodic_task_timer_table verification clean");
		end else begin
			$display("periodic_task_timer_table verification failed");
		end
		$finish;
	end

endmodule

[filelist.f]
hw/rtl/ptt_pkg.sv
hw/rtl/ptt_if.sv
hw/rtl/ptt_front.sv
hw/rtl/ptt_cmd_queue.sv
hw/rtl/ptt_back.sv
hw/rtl/periodic_task_timer_table.sv
hw/rtl/ptt_checker.sv
dv/tb_periodic_task_timer_table.sv
